@@ src/rmi_pkg.sv @@
// ----------------------------------------------------------------------------
// rmi_pkg: shared constants and types for the running median insert unit
// Sizes of the sorted cell chain and the flag bundle passed between cells.
// ----------------------------------------------------------------------------
package rmi_pkg;

    localparam int CAPACITY   = 1024;
    localparam int SAMPLE_W   = 32;
    localparam int MEDIAN_W   = SAMPLE_W + 1;
    localparam int COUNT_W    = 11;
    localparam int CNT_W      = $clog2(CAPACITY + 1);
    // cell that always holds the upper middle sample
    localparam int HALF       = CAPACITY / 2;

    typedef logic signed [SAMPLE_W-1:0] sample_t;

    // status one cell shows to its neighbors
    typedef struct packed {
        logic occ;  // cell holds a stored sample
        logic gt;   // stored sample is greater than the incoming one
    } cell_flags_t;

endpackage

@@ src/rmi_cell.sv @@
// ----------------------------------------------------------------------------
// rmi_cell: one slot of the sorted insertion chain
// Holds one sample; on insert keeps it, takes a neighbor's, or takes the new one.
// ----------------------------------------------------------------------------
module rmi_cell
    import rmi_pkg::*;
(
    input  logic        clk,
    input  logic        load,
    input  logic        shift_left,
    input  sample_t     sample,
    input  logic        occ,
    input  sample_t     left_value,
    input  cell_flags_t left_flags,
    input  sample_t     right_value,
    input  cell_flags_t right_flags,
    output sample_t     value,
    output sample_t     value_next,
    output cell_flags_t flags
);

    sample_t value_reg;
    logic    gt;
    logic    take_nb;
    logic    keep;
    sample_t nb_value;

    assign gt    = value_reg > sample;
    assign flags = '{occ: occ, gt: gt};
    assign value = value_reg;

    always_comb
    begin
        if (shift_left)
        begin
            // samples not above the new one move one slot left
            take_nb  = right_flags.occ & ~right_flags.gt;
            keep     = occ & gt;
            nb_value = right_value;
        end
        else
        begin
            // samples above the new one move one slot right
            take_nb  = left_flags.occ & left_flags.gt;
            keep     = occ & ~gt;
            nb_value = left_value;
        end

        if (!load)
            value_next = value_reg;
        else if (take_nb)
            value_next = nb_value;
        else if (keep)
            value_next = value_reg;
        else
            value_next = sample;
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

endmodule

@@ src/running_median_insert_unit.sv @@
// ----------------------------------------------------------------------------
// running_median_insert_unit: running median over all samples since reset
// Sorted chain of cells with the median pinned at the chain's center.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: sample with sample_valid / sample_ready. Output channel:
//   median_doubled, stored_count, dropped with result_valid / result_ready.
//   Every item gives one result: twice the median of the stored set (sum of
//   the two middle samples when the count is even).
//   The stored samples sit in sorted order in a row of cells placed so that
//   the upper middle sample is always in the center cell. Each insert moves
//   one side of the row by one slot toward the new sample's place, so the
//   median cells are known without any search.
//   The result is registered at the edge that accepts the item. Throughput:
//   one item per cycle while the receiver takes each result, set by the
//   single compare-and-shift step of the cell row plus the median add.
//   When the store is full the sample is dropped, dropped is set and the
//   median of the unchanged set is reported.
//   A stalled receiver holds the result; sample_ready stays low until it is
//   taken. Reset empties the store at once (count to zero); the cell
//   contents are left as they are and are never read before being written.
// ----------------------------------------------------------------------------
module running_median_insert_unit
    import rmi_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       sample_valid,
    output logic                       sample_ready,
    input  logic signed [SAMPLE_W-1:0] sample,
    output logic                       result_valid,
    input  logic                       result_ready,
    output logic signed [MEDIAN_W-1:0] median_doubled,
    output logic [COUNT_W-1:0]         stored_count,
    output logic                       dropped
);

    logic [CNT_W-1:0]          held_count_reg;
    logic [CNT_W-1:0]          held_count_next;
    logic                      result_valid_reg;
    logic signed [MEDIAN_W-1:0] median_reg;
    logic [COUNT_W-1:0]        count_reg;
    logic                      dropped_reg;

    logic                      accept;
    logic                      full;
    logic                      load;
    logic [CNT_W-1:0]          occ_lo;
    logic [CNT_W-1:0]          occ_hi;
    logic signed [MEDIAN_W-1:0] median_next;

    sample_t     cell_value      [0:CAPACITY+1];
    cell_flags_t cell_flags      [0:CAPACITY+1];
    sample_t     cell_value_next [0:CAPACITY-1];

    // accept while the output register is free or being emptied
    assign sample_ready = ~result_valid_reg | result_ready;
    assign accept       = sample_valid & sample_ready;
    assign full         = held_count_reg == CNT_W'(CAPACITY);
    assign load         = accept & ~full;

    // occupied cells span HALF - n/2 up to that plus n - 1
    assign occ_lo = CNT_W'(HALF) - (held_count_reg >> 1);
    assign occ_hi = occ_lo + held_count_reg - CNT_W'(1);

    // pad cells at both ends read as empty
    assign cell_value[0]          = '0;
    assign cell_flags[0]          = '{occ: 1'b0, gt: 1'b0};
    assign cell_value[CAPACITY+1] = '0;
    assign cell_flags[CAPACITY+1] = '{occ: 1'b0, gt: 1'b0};

    genvar c;
    generate
        for (c = 0; c < CAPACITY; c++)
        begin : g_cell
            logic occ;
            assign occ = (CNT_W'(c) >= occ_lo) && (CNT_W'(c) <= occ_hi);

            rmi_cell u_cell (
                .clk         (clk),
                .load        (load),
                .shift_left  (held_count_reg[0]),
                .sample      (sample),
                .occ         (occ),
                .left_value  (cell_value[c]),
                .left_flags  (cell_flags[c]),
                .right_value (cell_value[c+2]),
                .right_flags (cell_flags[c+2]),
                .value       (cell_value[c+1]),
                .value_next  (cell_value_next[c]),
                .flags       (cell_flags[c+1])
            );
        end
    endgenerate

    assign held_count_next = load ? held_count_reg + CNT_W'(1) : held_count_reg;

    // median from the cells' next contents: center cell, plus its left neighbor when the count is even
    always_comb
    begin
        if (held_count_next[0])
            median_next = {cell_value_next[HALF], 1'b0};
        else
            median_next = {cell_value_next[HALF-1][SAMPLE_W-1], cell_value_next[HALF-1]}
                        + {cell_value_next[HALF][SAMPLE_W-1], cell_value_next[HALF]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_count_reg   <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            held_count_reg <= held_count_next;
            if (accept)
                result_valid_reg <= 1'b1;
            else if (result_ready)
                result_valid_reg <= 1'b0;
        end
    end

    // hold the result until taken
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            median_reg  <= median_next;
            count_reg   <= COUNT_W'(held_count_next);
            dropped_reg <= full;
        end
    end

    assign result_valid   = result_valid_reg;
    assign median_doubled = median_reg;
    assign stored_count   = count_reg;
    assign dropped        = dropped_reg;

endmodule
